### hdl/mlrq_pkg.sv
// Shared types, constants and helpers for the multilevel ready queue.
`timescale 1ns / 1ps
`default_nettype none
package mlrq_pkg;

   localparam int READY_SLOTS = 16;
   localparam int SLOT_W      = (READY_SLOTS > 1) ? $clog2(READY_SLOTS) : 1;

   localparam logic [7:0]  PRIO_MAX      = 8'd149;
   localparam logic [7:0]  LEVEL1_MIN    = 8'd100;
   localparam logic [7:0]  LEVEL2_MIN    = 8'd50;
   localparam logic [15:0] AGE_WAIT_RST  = 16'd1500;
   localparam logic [7:0]  AGE_BOOST_RST = 8'd10;

   typedef enum logic [1:0] {
      CMD_ENQ = 2'd0,
      CMD_DEQ = 2'd1,
      CMD_AGE = 2'd2,
      CMD_NOP = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_EMPTY = 2'd1,
      STAT_FULL  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      LVL_NONE = 2'd0,
      LVL_1    = 2'd1,
      LVL_2    = 2'd2,
      LVL_3    = 2'd3
   } level_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_DRAIN,
      S_FIN
   } fsm_type;

   typedef struct packed {
      logic [1:0]  level;
      logic [7:0]  id;
      logic [7:0]  prio;
      logic [31:0] burst;
      logic [30:0] ready;
      logic [31:0] waiting;
      logic [15:0] seq;
   } entry_type;

   typedef struct packed {
      logic [15:0] wait_ticks;
      logic [7:0]  boost;
   } csr_type;

   // clamp a 34-bit two's complement value to the signed 32-bit range
   function automatic logic [31:0] sat32(input logic [33:0] v);
      logic [31:0] r;
      if (!v[33] && (v[32:31] != 2'b00)) r = 32'h7FFF_FFFF;
      else if (v[33] && (v[32:31] != 2'b11)) r = 32'h8000_0000;
      else r = v[31:0];
      return r;
   endfunction

   // arrival number a is earlier than b, modulo wrap
   function automatic logic seq_before(input logic [15:0] a, input logic [15:0] b);
      logic [15:0] d;
      d = b - a;
      return (d != 16'd0) && !d[15];
   endfunction

endpackage
`default_nettype wire

### hdl/mlrq_csr.sv
// APB register block: aging threshold and boost.
`timescale 1ns / 1ps
`default_nettype none
module mlrq_csr (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   psel,
   input  wire                   penable,
   input  wire                   pwrite,
   input  wire  [2:0]            paddr,
   input  wire  [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready,
   output mlrq_pkg::csr_type     csr
);
   import mlrq_pkg::*;

   logic [15:0] wait_ff;
   logic [7:0]  boost_ff;
   logic        wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         wait_ff  <= AGE_WAIT_RST;
         boost_ff <= AGE_BOOST_RST;
      end else if (wr_en) begin
         if (paddr[2]) boost_ff <= pwdata[7:0];
         else wait_ff <= pwdata[15:0];
      end
   end

   always_comb begin
      if (paddr[2]) prdata = {24'd0, boost_ff};
      else prdata = {16'd0, wait_ff};
   end

   assign csr.wait_ticks = wait_ff;
   assign csr.boost      = boost_ff;

endmodule
`default_nettype wire

### hdl/multilevel_ready_queue_aging_top.sv
// Top level of the multilevel ready queue with aging.
//
// Commands enter on start/busy: a word is taken at a clock edge with start high
// and busy low, and busy stays high until its result has been produced. The
// result shows on the rsp_ ports for one cycle with rsp_valid high; the
// receiver cannot stall, so it must take it then.
// Entries live in one synchronous memory of READY_SLOTS words; slot valid bits
// sit in flip-flops. Commands sweep the memory one slot per cycle:
//   enqueue, dequeue : one sweep
//   age              : one sweep per level
//   enqueue into a full table, no-op : no sweep
// The sweep length is set by the single memory read port; aging adds a two
// stage read-modify-write behind the read.
// Reset (synchronous) empties the table, clears the arrival counter and loads
// the register defaults; no clearing pass is needed.
// Registers: 0x0 aging wait threshold, 0x4 aging boost.
`timescale 1ns / 1ps
`default_nettype none
module multilevel_ready_queue_aging_top (
   input  wire          clock,
   input  wire          reset,
   input  wire          start,
   output logic         busy,
   input  wire  [1:0]   req_command,
   input  wire  [7:0]   req_thread_id,
   input  wire  [7:0]   req_thread_priority,
   input  wire  [31:0]  req_burst_estimate,
   input  wire  [31:0]  req_waiting_ticks,
   input  wire  [30:0]  req_now_tick,
   input  wire  [7:0]   req_running_id,
   input  wire  [7:0]   req_running_priority,
   input  wire  [31:0]  req_running_burst,
   output logic         rsp_valid,
   output logic [1:0]   rsp_status,
   output logic [7:0]   rsp_chosen_id,
   output logic [7:0]   rsp_chosen_priority,
   output logic [31:0]  rsp_chosen_burst,
   output logic [31:0]  rsp_chosen_waiting,
   output logic [1:0]   rsp_chosen_level,
   output logic         rsp_preempt_running,
   input  wire          psel,
   input  wire          penable,
   input  wire          pwrite,
   input  wire  [2:0]   paddr,
   input  wire  [31:0]  pwdata,
   output logic [31:0]  prdata,
   output logic         pready
);
   import mlrq_pkg::*;

   csr_type csr;

   mlrq_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .csr     (csr)
   );

   fsm_type state_ff, state_in;
   cmd_type cmd_ff;
   logic [7:0]  tid_ff, tprio_ff, rid_ff, rprio_ff;
   logic [31:0] tburst_ff, rburst_ff;
   logic [30:0] now_ff;
   logic        full_ff;

   logic [SLOT_W-1:0] idx_ff, idx_in;
   logic [1:0]        pass_ff, pass_in;
   logic              drain_ff, drain_in;

   logic [READY_SLOTS-1:0] valid_ff;
   logic [15:0]            seq_ff;

   entry_type mem [READY_SLOTS];
   entry_type rd_q_ff;
   logic      rd_en;
   logic      wr_en;
   logic [SLOT_W-1:0] wr_addr;
   entry_type wr_data;

   logic              s1_vld_ff;
   logic [SLOT_W-1:0] s1_slot_ff;
   logic [1:0]        s1_pass_ff;

   logic              s2_vld_ff;
   logic [SLOT_W-1:0] s2_slot_ff;
   entry_type         s2_ent_ff;
   logic [31:0]       s2_diff_ff;
   logic [33:0]       s2_wait_ff;
   logic [32:0]       s2_wsub_ff;

   logic              rid_hit_ff, preempt_ff;
   logic              best_vld_ff;
   entry_type         best_ff;
   logic [SLOT_W-1:0] best_slot_ff;

   logic        accept;
   logic        full;
   logic [SLOT_W-1:0] free_slot;
   logic [1:0]  new_level;
   logic        fin_en;

   assign busy   = (state_ff != S_IDLE);
   assign accept = start && !busy;

   always_comb begin
      full      = &valid_ff;
      free_slot = '0;
      for (int i = READY_SLOTS - 1; i >= 0; i--) begin
         if (!valid_ff[i]) free_slot = SLOT_W'(i);
      end
   end

   always_comb begin
      if (req_thread_priority >= LEVEL1_MIN) new_level = LVL_1;
      else if (req_thread_priority >= LEVEL2_MIN) new_level = LVL_2;
      else new_level = LVL_3;
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      pass_in  = pass_ff;
      drain_in = drain_ff;
      rd_en    = 1'b0;
      fin_en   = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               idx_in   = '0;
               pass_in  = LVL_1;
               drain_in = 1'b0;
               if (cmd_type'(req_command) == CMD_NOP) state_in = S_FIN;
               else if (cmd_type'(req_command) == CMD_ENQ && full) state_in = S_FIN;
               else state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            rd_en = 1'b1;
            if (idx_ff == SLOT_W'(READY_SLOTS - 1)) begin
               idx_in = '0;
               if (cmd_ff == CMD_AGE && pass_ff != LVL_3) pass_in = pass_ff + 2'd1;
               else state_in = S_DRAIN;
            end else begin
               idx_in = idx_ff + SLOT_W'(1);
            end
         end
         S_DRAIN: begin
            drain_in = 1'b1;
            if (drain_ff) state_in = S_FIN;
         end
         S_FIN: begin
            fin_en   = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      idx_ff   <= idx_in;
      pass_ff  <= pass_in;
      drain_ff <= drain_in;
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff    <= cmd_type'(req_command);
         tid_ff    <= req_thread_id;
         tprio_ff  <= req_thread_priority;
         tburst_ff <= req_burst_estimate;
         now_ff    <= req_now_tick;
         rid_ff    <= req_running_id;
         rprio_ff  <= req_running_priority;
         rburst_ff <= req_running_burst;
         full_ff   <= full;
      end
   end

   // stage 1: memory word arrives
   logic        s1_take;
   logic        s1_better;
   logic [31:0] s1_diff;
   logic [33:0] s1_wait;
   logic [32:0] s1_wsub;
   logic        s1_age;
   logic        s1_hit;

   always_comb begin
      s1_diff = {1'b0, now_ff} - {1'b0, rd_q_ff.ready};
      s1_wait = {{2{s1_diff[31]}}, s1_diff} + {{2{rd_q_ff.waiting[31]}}, rd_q_ff.waiting};
      s1_wsub = {rd_q_ff.waiting[31], rd_q_ff.waiting} - {17'd0, csr.wait_ticks};
      s1_age  = s1_vld_ff && (cmd_ff == CMD_AGE) && valid_ff[s1_slot_ff]
                && (rd_q_ff.level == s1_pass_ff);
      // level-1 entries of the running thread block preemption
      s1_hit  = s1_vld_ff && (cmd_ff != CMD_DEQ) && valid_ff[s1_slot_ff]
                && (rd_q_ff.level == LVL_1) && (rd_q_ff.id == rid_ff);
      if (rd_q_ff.level == LVL_1 && rd_q_ff.burst != best_ff.burst)
         s1_better = rd_q_ff.burst < best_ff.burst;
      else if (rd_q_ff.level == LVL_2 && rd_q_ff.prio != best_ff.prio)
         s1_better = rd_q_ff.prio > best_ff.prio;
      else
         s1_better = seq_before(rd_q_ff.seq, best_ff.seq);
      s1_take = s1_vld_ff && (cmd_ff == CMD_DEQ) && valid_ff[s1_slot_ff]
                && (!best_vld_ff || (rd_q_ff.level < best_ff.level)
                    || ((rd_q_ff.level == best_ff.level) && s1_better));
   end

   // stage 2: aging decision and write back
   logic        s2_event;
   logic [31:0] s2_wsat;
   logic [33:0] s2_wmove;
   logic [8:0]  s2_sum;
   logic [7:0]  s2_newp;
   logic        s2_to_l1, s2_to_l2, s2_reseq;
   entry_type   s2_new;
   logic        s2_pre;

   always_comb begin
      s2_event = s2_vld_ff && ($signed(s2_wait_ff) >= $signed({18'd0, csr.wait_ticks}));
      s2_wsat  = sat32({s2_wsub_ff[32], s2_wsub_ff});
      s2_wmove = {{2{s2_wsat[31]}}, s2_wsat} + {{2{s2_diff_ff[31]}}, s2_diff_ff};
      s2_sum   = {1'b0, s2_ent_ff.prio} + {1'b0, csr.boost};
      s2_newp  = (s2_sum > {1'b0, PRIO_MAX}) ? PRIO_MAX : s2_sum[7:0];
      s2_to_l1 = (s2_newp >= LEVEL1_MIN) && (s2_ent_ff.prio < LEVEL1_MIN);
      s2_to_l2 = !s2_to_l1 && (s2_newp >= LEVEL2_MIN) && (s2_ent_ff.prio < LEVEL2_MIN);
      s2_reseq = !s2_to_l1 && !s2_to_l2 && (s2_ent_ff.level == LVL_2)
                 && (s2_newp != s2_ent_ff.prio);
      s2_new         = s2_ent_ff;
      s2_new.prio    = s2_newp;
      s2_new.waiting = s2_wsat;
      if (s2_to_l1) begin
         s2_new.waiting = sat32(s2_wmove);
         s2_new.ready   = now_ff;
         s2_new.level   = LVL_1;
         s2_new.seq     = seq_ff;
      end else if (s2_to_l2) begin
         s2_new.level = LVL_2;
         s2_new.seq   = seq_ff;
      end else if (s2_reseq) begin
         s2_new.seq = seq_ff;
      end
      s2_pre = (rid_ff != s2_ent_ff.id) && !rid_hit_ff
               && ((rprio_ff >= LEVEL1_MIN) ? (rburst_ff > s2_ent_ff.burst)
                                            : (rid_ff != 8'd0));
   end

   // memory write port: enqueue at accept, aging write back otherwise
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = s2_slot_ff;
      wr_data = s2_new;
      if (accept && cmd_type'(req_command) == CMD_ENQ && !full) begin
         wr_en           = 1'b1;
         wr_addr         = free_slot;
         wr_data.level   = new_level;
         wr_data.id      = req_thread_id;
         wr_data.prio    = req_thread_priority;
         wr_data.burst   = req_burst_estimate;
         wr_data.ready   = req_now_tick;
         wr_data.waiting = req_waiting_ticks;
         wr_data.seq     = seq_ff;
      end else if (s2_event) begin
         wr_en = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
   end

   always_ff @(posedge clock) begin
      if (rd_en) rd_q_ff <= mem[idx_ff];
   end

   logic enq_wr;
   assign enq_wr = accept && cmd_type'(req_command) == CMD_ENQ && !full;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff   <= 1'b0;
         s2_vld_ff   <= 1'b0;
         valid_ff    <= '0;
         seq_ff      <= '0;
         rid_hit_ff  <= 1'b0;
         preempt_ff  <= 1'b0;
         best_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= rd_en;
         s2_vld_ff <= s1_age;
         if (accept) begin
            rid_hit_ff  <= 1'b0;
            preempt_ff  <= 1'b0;
            best_vld_ff <= 1'b0;
         end else begin
            if (s1_hit || (s2_event && s2_to_l1 && (s2_ent_ff.id == rid_ff)))
               rid_hit_ff <= 1'b1;
            if (s2_event && s2_to_l1 && s2_pre) preempt_ff <= 1'b1;
            if (s1_take) best_vld_ff <= 1'b1;
         end
         if (enq_wr) valid_ff[free_slot] <= 1'b1;
         else if (fin_en && cmd_ff == CMD_DEQ && best_vld_ff)
            valid_ff[best_slot_ff] <= 1'b0;
         if (enq_wr || (s2_event && (s2_to_l1 || s2_to_l2 || s2_reseq)))
            seq_ff <= seq_ff + 16'd1;
      end
   end

   always_ff @(posedge clock) begin
      s1_slot_ff <= idx_ff;
      s1_pass_ff <= pass_ff;
      s2_slot_ff <= s1_slot_ff;
      s2_ent_ff  <= rd_q_ff;
      s2_diff_ff <= s1_diff;
      s2_wait_ff <= s1_wait;
      s2_wsub_ff <= s1_wsub;
      if (s1_take) begin
         best_ff      <= rd_q_ff;
         best_slot_ff <= s1_slot_ff;
      end
   end

   // result word
   logic        rsp_valid_ff;
   logic [1:0]  rsp_status_ff, rsp_status_in;
   logic [7:0]  rsp_id_ff, rsp_id_in, rsp_prio_ff, rsp_prio_in;
   logic [31:0] rsp_burst_ff, rsp_burst_in, rsp_wait_ff, rsp_wait_in;
   logic [1:0]  rsp_level_ff, rsp_level_in;
   logic        rsp_pre_ff, rsp_pre_in;
   logic [31:0] fin_diff;
   logic        enq_pre;

   always_comb begin
      fin_diff = {1'b0, now_ff} - {1'b0, best_ff.ready};
      enq_pre  = (tprio_ff >= LEVEL1_MIN) && (rid_ff != tid_ff) && !rid_hit_ff
                 && ((rprio_ff >= LEVEL1_MIN) ? (rburst_ff > tburst_ff)
                                              : (rid_ff != 8'd0));
      rsp_status_in = STAT_OK;
      rsp_id_in     = '0;
      rsp_prio_in   = '0;
      rsp_burst_in  = '0;
      rsp_wait_in   = '0;
      rsp_level_in  = LVL_NONE;
      rsp_pre_in    = 1'b0;
      case (cmd_ff)
         CMD_ENQ: begin
            if (full_ff) rsp_status_in = STAT_FULL;
            else rsp_pre_in = enq_pre;
         end
         CMD_DEQ: begin
            if (!best_vld_ff) begin
               rsp_status_in = STAT_EMPTY;
            end else begin
               rsp_id_in    = best_ff.id;
               rsp_prio_in  = best_ff.prio;
               rsp_burst_in = best_ff.burst;
               rsp_wait_in  = sat32({{2{best_ff.waiting[31]}}, best_ff.waiting}
                                    + {{2{fin_diff[31]}}, fin_diff});
               rsp_level_in = best_ff.level;
            end
         end
         CMD_AGE: rsp_pre_in = preempt_ff;
         default: rsp_status_in = STAT_OK;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= fin_en;
      end
      if (fin_en) begin
         rsp_status_ff <= rsp_status_in;
         rsp_id_ff     <= rsp_id_in;
         rsp_prio_ff   <= rsp_prio_in;
         rsp_burst_ff  <= rsp_burst_in;
         rsp_wait_ff   <= rsp_wait_in;
         rsp_level_ff  <= rsp_level_in;
         rsp_pre_ff    <= rsp_pre_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_chosen_id       = rsp_id_ff;
   assign rsp_chosen_priority = rsp_prio_ff;
   assign rsp_chosen_burst    = rsp_burst_ff;
   assign rsp_chosen_waiting  = rsp_wait_ff;
   assign rsp_chosen_level    = rsp_level_ff;
   assign rsp_preempt_running = rsp_pre_ff;

   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (state_ff == S_IDLE))
      else $error("result word while a command is in flight");

   a_rsp_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff)
      else $error("result strobe longer than one cycle");

   a_s2_age: assert property (@(posedge clock) disable iff (reset)
      s2_vld_ff |-> (cmd_ff == CMD_AGE && state_ff != S_IDLE))
      else $error("write-back stage active outside an aging sweep");

   a_wr_clash: assert property (@(posedge clock) disable iff (reset)
      accept |-> !s2_vld_ff && !s1_vld_ff)
      else $error("new command accepted while the sweep pipeline is busy");

   a_enq_slot: assert property (@(posedge clock) disable iff (reset)
      enq_wr |=> valid_ff[$past(free_slot)])
      else $error("enqueue did not claim its slot");

endmodule
`default_nettype wire

### verif/multilevel_ready_queue_aging_top_tb.sv
// Self-checking testbench for the multilevel ready queue with aging.
`timescale 1ns / 1ps
`default_nettype none
module multilevel_ready_queue_aging_top_tb;
   import mlrq_pkg::*;

   localparam int IDLE_LIMIT = 4000;

   typedef struct {
      cmd_type     cmd;
      logic [7:0]  tid;
      logic [7:0]  tprio;
      logic [31:0] tburst;
      logic [31:0] twait;
      logic [30:0] now;
      logic [7:0]  rid;
      logic [7:0]  rprio;
      logic [31:0] rburst;
   } sched_req_type;

   typedef struct {
      status_type  status;
      logic [7:0]  cid;
      logic [7:0]  cprio;
      logic [31:0] cburst;
      logic [31:0] cwait;
      level_type   clevel;
      logic        preempt;
   } sched_rsp_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_command = '0;
   logic [7:0]  req_thread_id = '0;
   logic [7:0]  req_thread_priority = '0;
   logic [31:0] req_burst_estimate = '0;
   logic [31:0] req_waiting_ticks = '0;
   logic [30:0] req_now_tick = '0;
   logic [7:0]  req_running_id = '0;
   logic [7:0]  req_running_priority = '0;
   logic [31:0] req_running_burst = '0;
   logic        rsp_valid;
   logic [1:0]  rsp_status;
   logic [7:0]  rsp_chosen_id;
   logic [7:0]  rsp_chosen_priority;
   logic [31:0] rsp_chosen_burst;
   logic [31:0] rsp_chosen_waiting;
   logic [1:0]  rsp_chosen_level;
   logic        rsp_preempt_running;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [2:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   always #5 clock = ~clock;

   multilevel_ready_queue_aging_top i_dut (
      .clock, .reset, .start, .busy,
      .req_command, .req_thread_id, .req_thread_priority, .req_burst_estimate,
      .req_waiting_ticks, .req_now_tick, .req_running_id, .req_running_priority,
      .req_running_burst,
      .rsp_valid, .rsp_status, .rsp_chosen_id, .rsp_chosen_priority,
      .rsp_chosen_burst, .rsp_chosen_waiting, .rsp_chosen_level, .rsp_preempt_running,
      .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
   );

   // scheduler shadow state
   logic [15:0] age_thresh;
   logic [7:0]  age_boost;
   bit          slot_used [READY_SLOTS];
   logic [1:0]  slot_level [READY_SLOTS];
   logic [7:0]  slot_id [READY_SLOTS];
   logic [7:0]  slot_prio [READY_SLOTS];
   logic [31:0] slot_burst [READY_SLOTS];
   logic [30:0] slot_ready [READY_SLOTS];
   longint      slot_wait [READY_SLOTS];
   logic [15:0] slot_seq [READY_SLOTS];
   logic [15:0] arrival_no;

   sched_rsp_type pending_rsp [$];
   int          fail_cnt = 0;
   int          idle_cycles = 0;
   bit          gaps_on = 1'b1;
   logic [30:0] tick_now = '0;

   function automatic longint clamp32(input longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic bit earlier(input logic [15:0] a, input logic [15:0] b);
      logic [15:0] d;
      d = b - a;
      return d != 0 && !d[15];
   endfunction

   function automatic logic [15:0] take_arrival();
      logic [15:0] s;
      s = arrival_no;
      arrival_no = arrival_no + 16'd1;
      return s;
   endfunction

   function automatic bit preempts(input logic [7:0] id, input logic [31:0] burst,
                                   input sched_req_type r);
      if (r.rid == id) return 1'b0;
      for (int i = 0; i < READY_SLOTS; i++)
         if (slot_used[i] && slot_level[i] == LVL_1 && slot_id[i] == r.rid) return 1'b0;
      if (r.rprio >= LEVEL1_MIN) return r.rburst > burst;
      return r.rid != 0;
   endfunction

   function automatic bit served_first(input int a, input int b);
      if (slot_level[a] == LVL_1 && slot_burst[a] != slot_burst[b])
         return slot_burst[a] < slot_burst[b];
      if (slot_level[a] == LVL_2 && slot_prio[a] != slot_prio[b])
         return slot_prio[a] > slot_prio[b];
      return earlier(slot_seq[a], slot_seq[b]);
   endfunction

   function automatic sched_rsp_type schedule(input sched_req_type r);
      sched_rsp_type o;
      int         slot;
      int         best;
      longint     w;
      int         sum;
      logic [7:0] oldp;
      logic [7:0] newp;
      bit         seen [READY_SLOTS];
      o = '{STAT_OK, 0, 0, 0, 0, LVL_NONE, 0};
      case (r.cmd)
         CMD_ENQ: begin
            slot = -1;
            for (int i = READY_SLOTS - 1; i >= 0; i--) if (!slot_used[i]) slot = i;
            if (slot < 0) begin
               o.status = STAT_FULL;
            end else begin
               slot_used[slot]  = 1'b1;
               slot_level[slot] = r.tprio >= LEVEL1_MIN ? LVL_1 :
                                  (r.tprio >= LEVEL2_MIN ? LVL_2 : LVL_3);
               slot_id[slot]    = r.tid;
               slot_prio[slot]  = r.tprio;
               slot_burst[slot] = r.tburst;
               slot_ready[slot] = r.now;
               slot_wait[slot]  = longint'(signed'(r.twait));
               slot_seq[slot]   = take_arrival();
               if (slot_level[slot] == LVL_1)
                  o.preempt = preempts(r.tid, r.tburst, r);
            end
         end
         CMD_DEQ: begin
            best = -1;
            for (int lv = 1; lv <= 3 && best < 0; lv++)
               for (int i = 0; i < READY_SLOTS; i++)
                  if (slot_used[i] && slot_level[i] == lv)
                     if (best < 0 || served_first(i, best)) best = i;
            if (best < 0) begin
               o.status = STAT_EMPTY;
            end else begin
               w = clamp32(slot_wait[best] + longint'(r.now) - longint'(slot_ready[best]));
               slot_used[best] = 1'b0;
               o.cid    = slot_id[best];
               o.cprio  = slot_prio[best];
               o.cburst = slot_burst[best];
               o.cwait  = w[31:0];
               o.clevel = level_type'(slot_level[best]);
            end
         end
         CMD_AGE: begin
            foreach (seen[i]) seen[i] = 1'b0;
            for (int lv = 1; lv <= 3; lv++)
               for (int i = 0; i < READY_SLOTS; i++) begin
                  if (!slot_used[i] || seen[i] || slot_level[i] != lv) continue;
                  seen[i] = 1'b1;
                  w = longint'(r.now) - longint'(slot_ready[i]) + slot_wait[i];
                  if (w < longint'(age_thresh)) continue;
                  slot_wait[i] = clamp32(slot_wait[i] - longint'(age_thresh));
                  oldp = slot_prio[i];
                  sum  = int'(oldp) + int'(age_boost);
                  newp = sum > PRIO_MAX ? PRIO_MAX : sum[7:0];
                  slot_prio[i] = newp;
                  if (newp >= LEVEL1_MIN && oldp < LEVEL1_MIN) begin
                     slot_wait[i]  = clamp32(slot_wait[i] + longint'(r.now)
                                             - longint'(slot_ready[i]));
                     slot_ready[i] = r.now;
                     slot_level[i] = LVL_1;
                     slot_seq[i]   = take_arrival();
                     if (preempts(slot_id[i], slot_burst[i], r)) o.preempt = 1'b1;
                  end else if (newp >= LEVEL2_MIN && oldp < LEVEL2_MIN) begin
                     slot_level[i] = LVL_2;
                     slot_seq[i]   = take_arrival();
                  end else if (slot_level[i] == LVL_2 && newp != oldp) begin
                     slot_seq[i] = take_arrival();
                  end
               end
         end
         default: ;
      endcase
      return o;
   endfunction

   // drive one word, wait for acceptance; start stays high afterwards unless a random gap drops it
   task automatic issue(input sched_req_type r);
      start                <= 1'b1;
      req_command          <= r.cmd;
      req_thread_id        <= r.tid;
      req_thread_priority  <= r.tprio;
      req_burst_estimate   <= r.tburst;
      req_waiting_ticks    <= r.twait;
      req_now_tick         <= r.now;
      req_running_id       <= r.rid;
      req_running_priority <= r.rprio;
      req_running_burst    <= r.rburst;
      do @(posedge clock); while (busy);
      pending_rsp.push_back(schedule(r));
      if (gaps_on && $urandom_range(99) < 23) begin
         start <= 1'b0;
         repeat ($urandom_range(6, 1)) @(posedge clock);
      end
   endtask

   task automatic settle();
      start <= 1'b0;
      @(posedge clock);
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(input logic [2:0] addr, input logic [31:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      if (addr == 3'd0) age_thresh = data[15:0];
      else age_boost = data[7:0];
   endtask

   task automatic set_aging(input logic [15:0] thresh, input logic [7:0] boost);
      settle();
      csr_write(3'd0, {16'd0, thresh});
      csr_write(3'd4, {24'd0, boost});
   endtask

   function automatic sched_req_type mk(input cmd_type c, input logic [7:0] id,
                                        input logic [7:0] prio, input logic [31:0] burst,
                                        input logic [31:0] wt, input logic [30:0] now);
      sched_req_type r;
      r = '{c, id, prio, burst, wt, now, 8'd0, 8'd0, 32'd0};
      return r;
   endfunction

   function automatic sched_req_type random_req();
      sched_req_type r;
      int            pick;
      pick = $urandom_range(99);
      r.cmd = pick < 46 ? CMD_ENQ : pick < 76 ? CMD_DEQ : pick < 96 ? CMD_AGE : CMD_NOP;
      r.tid   = $urandom_range(255);
      r.tprio = $urandom_range(149);
      r.tburst = $urandom_range(9) == 0 ? $urandom : $urandom_range(200);
      case ($urandom_range(9))
         0: r.twait = $urandom;
         1: r.twait = $urandom_range(1) ? 32'h7FFF_FF00 : 32'h8000_0100;
         default: r.twait = $urandom_range(300) - 150;
      endcase
      tick_now = tick_now + 31'($urandom_range(600));
      r.now = $urandom_range(19) == 0 ? 31'($urandom) : tick_now;
      // running thread: sometimes the idle thread
      r.rid = $urandom_range(3) == 0 ? 8'd0 : 8'($urandom_range(255));
      r.rprio  = $urandom_range(149);
      r.rburst = $urandom_range(3) == 0 ? $urandom : $urandom_range(200);
      return r;
   endfunction

   task automatic test_empty_and_nop();
      issue(mk(CMD_DEQ, 0, 0, 0, 0, 0));
      issue(mk(CMD_NOP, 8'hFF, 149, '1, '1, '1));
      issue(mk(CMD_AGE, 0, 0, 0, 0, 31'h7FFF_FFFF));
   endtask

   task automatic test_levels_and_extremes();
      sched_req_type r;
      issue(mk(CMD_ENQ, 8'd1, 8'd0, 32'd0, 32'h8000_0000, 31'h7FFF_FFFF));
      issue(mk(CMD_ENQ, 8'd2, 8'd49, 32'd5, 32'd0, 31'd10));
      issue(mk(CMD_ENQ, 8'd3, 8'd50, 32'd7, 32'h7FFF_FFFF, 31'd0));
      issue(mk(CMD_ENQ, 8'd4, 8'd99, 32'd1, 32'd0, 31'd5));
      r = mk(CMD_ENQ, 8'hFF, 8'd149, 32'hFFFF_FFFF, 32'd3, 31'd20);
      r.rid = 8'd9; r.rprio = 8'd149; r.rburst = 32'hFFFF_FFFF;
      issue(r);
      r = mk(CMD_ENQ, 8'd6, 8'd100, 32'd0, 32'd0, 31'd20);
      r.rid = 8'd6;
      issue(r);
      // id 3 saturates high, id 1 sits on the signed floor, last word finds it empty
      for (int i = 0; i < 7; i++) issue(mk(CMD_DEQ, 0, 0, 0, 0, 31'h7FFF_FFFF));
   endtask

   task automatic test_preempt();
      sched_req_type r;
      r = mk(CMD_ENQ, 8'd10, 8'd120, 32'd50, 32'd0, 31'd100);
      r.rid = 8'd20; r.rprio = 8'd40;
      issue(r);
      r.tid = 8'd11; r.rid = 8'd10;
      issue(r);
      r.tid = 8'd12; r.rid = 8'd0; r.rprio = 8'd30;
      issue(r);
      r.tid = 8'd13; r.rid = 8'd30; r.rprio = 8'd110; r.rburst = 32'd50;
      issue(r);
      r.tid = 8'd14; r.rburst = 32'd51;
      issue(r);
   endtask

   task automatic test_aging_and_full();
      sched_req_type r;
      for (int i = 0; i < READY_SLOTS + 1; i++)
         issue(mk(CMD_ENQ, 8'(40 + i), 8'($urandom_range(45, 95)), $urandom_range(50),
                  32'd0, 31'd200));
      r = mk(CMD_AGE, 0, 0, 0, 0, 31'd1800);
      r.rid = 8'd77; r.rprio = 8'd10;
      issue(r);
      issue(r);
      settle();
      set_aging(16'd1, 8'd149);
      issue(r);
      set_aging(16'd65535, 8'd0);
      r.now = 31'h7FFF_FFFF;
      issue(r);
      for (int i = 0; i < READY_SLOTS + 1; i++) issue(mk(CMD_DEQ, 0, 0, 0, 0, 31'd90000));
   endtask

   task automatic test_random(input int count);
      for (int n = 0; n < count; n++) begin
         gaps_on = !(n >= 300 && n < 420);
         if (n % 220 == 219)
            set_aging($urandom_range(3) == 0 ? 16'($urandom_range(65535, 1))
                      : 16'($urandom_range(2000, 1)), $urandom_range(149));
         issue(random_req());
      end
      gaps_on = 1'b1;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (pending_rsp.size() == 0) begin
            $error("result word with nothing expected");
            fail_cnt++;
         end else begin
            sched_rsp_type e;
            e = pending_rsp.pop_front();
            if (rsp_status != e.status) begin
               $error("status exp %0d got %0d", e.status, rsp_status); fail_cnt++;
            end
            if (rsp_chosen_id != e.cid) begin
               $error("chosen_id exp %0d got %0d", e.cid, rsp_chosen_id); fail_cnt++;
            end
            if (rsp_chosen_priority != e.cprio) begin
               $error("chosen_priority exp %0d got %0d", e.cprio, rsp_chosen_priority);
               fail_cnt++;
            end
            if (rsp_chosen_burst != e.cburst) begin
               $error("chosen_burst exp %h got %h", e.cburst, rsp_chosen_burst); fail_cnt++;
            end
            if (rsp_chosen_waiting != e.cwait) begin
               $error("chosen_waiting exp %h got %h", e.cwait, rsp_chosen_waiting);
               fail_cnt++;
            end
            if (rsp_chosen_level != e.clevel) begin
               $error("chosen_level exp %0d got %0d", e.clevel, rsp_chosen_level);
               fail_cnt++;
            end
            if (rsp_preempt_running != e.preempt) begin
               $error("preempt_running exp %0d got %0d", e.preempt, rsp_preempt_running);
               fail_cnt++;
            end
         end
      end
   end

   // watchdog: cycles with neither a word taken nor a result
   always @(posedge clock) begin
      if (reset || rsp_valid || (start && !busy)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("multilevel_ready_queue_aging_top_tb NOT OK");
         $finish;
      end
   end

   initial begin
      age_thresh = AGE_WAIT_RST;
      age_boost  = AGE_BOOST_RST;
      arrival_no = '0;
      foreach (slot_used[i]) slot_used[i] = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_and_nop();
      test_levels_and_extremes();
      test_preempt();
      test_aging_and_full();
      set_aging(16'd1500, 8'd10);
      test_random(1100);
      settle();
      repeat (60) @(posedge clock);
      if (fail_cnt == 0 && pending_rsp.size() == 0)
         $display("multilevel_ready_queue_aging_top_tb OK");
      else
         $display("multilevel_ready_queue_aging_top_tb NOT OK");
      $finish;
   end

endmodule
`default_nettype wire

### filelist.f
hdl/mlrq_pkg.sv
hdl/mlrq_csr.sv
hdl/multilevel_ready_queue_aging_top.sv
verif/multilevel_ready_queue_aging_top_tb.sv
